// ===== hw/rtl/assert_macros.svh =====
// assertion helpers included by segment_projection_clamp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside of reset
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// shared widths, types and status codes of the segment projection block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spc_pkg;

   // coordinate and intermediate widths
   localparam int CW  = 32;          // coordinate
   localparam int DW  = CW + 1;      // coordinate difference
   localparam int PW  = 2 * DW;      // product of two differences
   localparam int SW  = PW + 1;      // sum of two products
   localparam int NW  = PW;          // magnitude of numerator and denominator
   localparam int PF  = 24;          // fraction bits of u
   localparam int QIB = 15;          // integer bits of the u limit
   localparam int QW  = QIB + PF + 1; // quotient magnitude bits
   localparam int NLW = QW - PF;     // low numerator bits shifted into the divider
   localparam int ULW = 32;          // low slice of |u| per multiplier
   localparam int UHW = QW - ULW;    // high slice of |u|
   localparam int PLW = ULW + DW;
   localparam int PHW = UHW + DW;
   localparam int PRW = PHW + ULW + 1;
   localparam int MGW = PRW - PF;
   localparam int VW  = MGW + 2;

   localparam logic [QW-1:0] U_LIMIT = QW'(1) << (QW - 1);
   localparam logic [QW-1:0] U_ONE   = QW'(1) << PF;

   typedef enum logic [1:0] {
      ST_INSIDE = 2'd0,
      ST_START  = 2'd1,
      ST_END    = 2'd2,
      ST_DEGEN  = 2'd3
   } spc_status_type;

   // data that rides alongside the divider
   typedef struct packed {
      logic [CW-1:0]        sx;
      logic [CW-1:0]        sy;
      logic [CW-1:0]        ex;
      logic [CW-1:0]        ey;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic                 degen;
      logic                 neg;
      logic                 qsat;
   } spc_side_type;

   // one divider stage
   typedef struct packed {
      logic [NW-1:0]  rem;
      logic [NW-1:0]  den;
      logic [NLW-1:0] nlow;
      logic [QW-1:0]  quo;
   } spc_div_type;

endpackage

// ===== hw/rtl/spc_divider.sv =====
// ----------------------------------------------------------------------------
// spc_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spc_divider import spc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  spc_div_type  in_div,
   input  spc_side_type in_side,
   output logic         out_valid,
   output logic [QW-1:0] out_quo,
   output spc_side_type out_side
);

   logic         valid_ff [QW];
   spc_div_type  div_ff   [QW];
   spc_side_type side_ff  [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int K = QW - 1 - j;
      spc_div_type  prev;
      spc_side_type prev_side;
      spc_div_type  div_in;
      logic         prev_valid;
      logic         bit_in;
      logic [NW:0]  rs;
      logic         ge;

      if (j == 0) begin : g_first
         assign prev       = in_div;
         assign prev_side  = in_side;
         assign prev_valid = in_valid;
      end else begin : g_next
         assign prev       = div_ff[j-1];
         assign prev_side  = side_ff[j-1];
         assign prev_valid = valid_ff[j-1];
      end

      // next dividend bit: low numerator bits, then zero fraction bits
      if (K >= PF) begin : g_bit
         assign bit_in = prev.nlow[K-PF];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end

      // shift, compare and subtract
      always_comb begin
         rs          = {prev.rem, bit_in};
         ge          = (rs >= {1'b0, prev.den});
         div_in      = prev;
         div_in.rem  = ge ? NW'(rs - {1'b0, prev.den}) : rs[NW-1:0];
         div_in.quo  = {prev.quo[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[j]  <= div_in;
            side_ff[j] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = div_ff[QW-1].quo;
   assign out_side  = side_ff[QW-1];

endmodule

// ===== hw/rtl/segment_projection_clamp.sv =====
// ----------------------------------------------------------------------------
// segment_projection_clamp
// nearest point on a segment and unclamped foot point, Q16.16 coordinates
// ----------------------------------------------------------------------------
// The block takes one query transaction per cycle and returns one result per
// query in order: four stages form differences, dot products and the
// numerator magnitude, 40 stages of the restoring divider each resolve one
// bit of u, and four stages clamp, multiply, round and saturate. The
// pipeline advances whenever the output register is empty or being taken,
// so throughput is one transaction per cycle while the result side keeps
// tready high.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module segment_projection_clamp import spc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y
   input  logic [191:0]  req_tdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // clamped_x, clamped_y, foot_x, foot_y
   output logic [127:0]  rsp_tdata,
   // clamp_status, foot_saturated
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready
);

   typedef struct packed {
      spc_side_type   side;
      logic [QW-1:0]  umag;
      spc_status_type status;
   } spc_post_type;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // stage 1: differences
   logic                 v1_ff;
   logic [CW-1:0]        sx1_ff, sy1_ff, ex1_ff, ey1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, cx1_ff, cy1_ff;
   logic [CW-1:0]        sx_in, sy_in, ex_in, ey_in, px_in, py_in;

   assign sx_in = req_tdata[31:0];
   assign sy_in = req_tdata[63:32];
   assign ex_in = req_tdata[95:64];
   assign ey_in = req_tdata[127:96];
   assign px_in = req_tdata[159:128];
   assign py_in = req_tdata[191:160];

   always_ff @(posedge clock) begin
      if (adv) begin
         sx1_ff <= sx_in;
         sy1_ff <= sy_in;
         ex1_ff <= ex_in;
         ey1_ff <= ey_in;
         dx1_ff <= $signed({ex_in[CW-1], ex_in}) - $signed({sx_in[CW-1], sx_in});
         dy1_ff <= $signed({ey_in[CW-1], ey_in}) - $signed({sy_in[CW-1], sy_in});
         cx1_ff <= $signed({px_in[CW-1], px_in}) - $signed({sx_in[CW-1], sx_in});
         cy1_ff <= $signed({py_in[CW-1], py_in}) - $signed({sy_in[CW-1], sy_in});
      end
   end

   // stage 2: dot product terms
   logic                 v2_ff;
   spc_side_type         side2_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pcx_ff, pcy_ff;
   spc_side_type         side2_in;

   always_comb begin
      side2_in       = '0;
      side2_in.sx    = sx1_ff;
      side2_in.sy    = sy1_ff;
      side2_in.ex    = ex1_ff;
      side2_in.ey    = ey1_ff;
      side2_in.dx    = dx1_ff;
      side2_in.dy    = dy1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
         pxx_ff   <= dx1_ff * dx1_ff;
         pyy_ff   <= dy1_ff * dy1_ff;
         pcx_ff   <= cx1_ff * dx1_ff;
         pcy_ff   <= cy1_ff * dy1_ff;
      end
   end

   // stage 3: squared length and numerator
   logic                 v3_ff;
   spc_side_type         side3_ff;
   logic [NW-1:0]        len2_ff;
   logic signed [SW-1:0] num_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side2_ff;
         len2_ff  <= NW'(pxx_ff) + NW'(pyy_ff);
         num_ff   <= $signed({pcx_ff[PW-1], pcx_ff}) + $signed({pcy_ff[PW-1], pcy_ff});
      end
   end

   // stage 4: numerator magnitude
   logic          v4_ff;
   spc_side_type  side4_ff;
   logic [NW-1:0] den_ff, nabs_ff;
   logic [SW-1:0] nabs_full;
   spc_side_type  side4_in;

   always_comb begin
      nabs_full      = num_ff[SW-1] ? (~num_ff + SW'(1)) : num_ff;
      side4_in       = side3_ff;
      side4_in.degen = (len2_ff == '0);
      side4_in.neg   = num_ff[SW-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side4_ff <= side4_in;
         den_ff   <= len2_ff;
         nabs_ff  <= nabs_full[NW-1:0];
      end
   end

   // divider entry: quotient overflow test and initial remainder
   spc_div_type  div_in;
   spc_side_type side_div_in;

   always_comb begin
      side_div_in      = side4_ff;
      side_div_in.qsat = ({{NLW{1'b0}}, nabs_ff} >= {den_ff, {NLW{1'b0}}});
      div_in.den       = den_ff;
      div_in.nlow      = nabs_ff[NLW-1:0];
      div_in.quo       = '0;
      div_in.rem       = side_div_in.qsat ? '0 : {{NLW{1'b0}}, nabs_ff[NW-1:NLW]};
   end

   logic          vd;
   logic [QW-1:0] quo_d;
   spc_side_type  side_d;

   spc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_div    (div_in),
      .in_side   (side_div_in),
      .out_valid (vd),
      .out_quo   (quo_d),
      .out_side  (side_d)
   );

   // stage 5: saturate u and decide status
   logic         v5_ff;
   spc_post_type post5_ff;
   spc_post_type post5_in;

   always_comb begin
      post5_in.side = side_d;
      if (side_d.qsat || (quo_d > U_LIMIT)) begin
         post5_in.umag = U_LIMIT;
      end else begin
         post5_in.umag = quo_d;
      end
      if (side_d.degen) begin
         post5_in.status = ST_DEGEN;
      end else if (side_d.neg || (post5_in.umag == '0)) begin
         post5_in.status = ST_START;
      end else if (post5_in.umag >= U_ONE) begin
         post5_in.status = ST_END;
      end else begin
         post5_in.status = ST_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         post5_ff <= post5_in;
      end
   end

   // stage 6: partial products of |u| and |d|
   logic           v6_ff;
   spc_post_type   post6_ff;
   logic [PLW-1:0] plx_ff, ply_ff;
   logic [PHW-1:0] phx_ff, phy_ff;
   logic           negx6_ff, negy6_ff;
   logic [DW-1:0]  dxm, dym;

   always_comb begin
      dxm = post5_ff.side.dx[DW-1] ? DW'(-post5_ff.side.dx) : DW'(post5_ff.side.dx);
      dym = post5_ff.side.dy[DW-1] ? DW'(-post5_ff.side.dy) : DW'(post5_ff.side.dy);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         post6_ff <= post5_ff;
         plx_ff   <= PLW'(post5_ff.umag[ULW-1:0]) * PLW'(dxm);
         ply_ff   <= PLW'(post5_ff.umag[ULW-1:0]) * PLW'(dym);
         phx_ff   <= PHW'(post5_ff.umag[QW-1:ULW]) * PHW'(dxm);
         phy_ff   <= PHW'(post5_ff.umag[QW-1:ULW]) * PHW'(dym);
         negx6_ff <= post5_ff.side.neg ^ post5_ff.side.dx[DW-1];
         negy6_ff <= post5_ff.side.neg ^ post5_ff.side.dy[DW-1];
      end
   end

   // stage 7: combine partials and round half away from zero
   logic           v7_ff;
   spc_post_type   post7_ff;
   logic [MGW-1:0] magx_ff, magy_ff;
   logic           negx7_ff, negy7_ff;
   logic [PRW-1:0] prodx, prody;

   always_comb begin
      prodx = {1'b0, phx_ff, {ULW{1'b0}}} + PRW'(plx_ff) + (PRW'(1) << (PF - 1));
      prody = {1'b0, phy_ff, {ULW{1'b0}}} + PRW'(ply_ff) + (PRW'(1) << (PF - 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         post7_ff <= post6_ff;
         magx_ff  <= prodx[PRW-1:PF];
         magy_ff  <= prody[PRW-1:PF];
         negx7_ff <= negx6_ff;
         negy7_ff <= negy6_ff;
      end
   end

   // stage 8: add start point, saturate, select clamped point
   logic                 v8_ff;
   logic [CW-1:0]        kx_ff, ky_ff, fx_ff, fy_ff;
   spc_status_type       status_ff;
   logic                 sat_ff;
   logic signed [VW-1:0] vx, vy;
   logic                 okx, oky;
   logic [CW-1:0]        fx_in, fy_in, kx_in, ky_in;
   logic                 sat_in;
   logic [CW-1:0]        cmax, cmin;

   always_comb begin
      cmax = {1'b0, {(CW-1){1'b1}}};
      cmin = {1'b1, {(CW-1){1'b0}}};
      vx = $signed(VW'($signed(post7_ff.side.sx)))
         + (negx7_ff ? -$signed({2'b00, magx_ff}) : $signed({2'b00, magx_ff}));
      vy = $signed(VW'($signed(post7_ff.side.sy)))
         + (negy7_ff ? -$signed({2'b00, magy_ff}) : $signed({2'b00, magy_ff}));
      okx = (vx[VW-1:CW-1] == '0) || (vx[VW-1:CW-1] == '1);
      oky = (vy[VW-1:CW-1] == '0) || (vy[VW-1:CW-1] == '1);
      fx_in = okx ? vx[CW-1:0] : (vx[VW-1] ? cmin : cmax);
      fy_in = oky ? vy[CW-1:0] : (vy[VW-1] ? cmin : cmax);
      sat_in = !okx || !oky;
      kx_in = fx_in;
      ky_in = fy_in;
      case (post7_ff.status)
         ST_INSIDE: begin
            kx_in = fx_in;
            ky_in = fy_in;
         end
         ST_START: begin
            kx_in = post7_ff.side.sx;
            ky_in = post7_ff.side.sy;
         end
         ST_END: begin
            kx_in = post7_ff.side.ex;
            ky_in = post7_ff.side.ey;
         end
         default: begin
            kx_in  = post7_ff.side.sx;
            ky_in  = post7_ff.side.sy;
            fx_in  = post7_ff.side.sx;
            fy_in  = post7_ff.side.sy;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kx_ff     <= kx_in;
         ky_ff     <= ky_in;
         fx_ff     <= fx_in;
         fy_ff     <= fy_in;
         status_ff <= post7_ff.status;
         sat_ff    <= sat_in;
      end
   end

   // valid bits of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= vd;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   assign rsp_tvalid = v8_ff;
   assign rsp_tdata  = {fy_ff, fx_ff, ky_ff, kx_ff};
   assign rsp_tuser  = {sat_ff, status_ff};

   `CHECK_IMPLY(a_degen_no_sat, clock, reset,
      rsp_tvalid && (status_ff == ST_DEGEN), !sat_ff,
      "degenerate segment reported a saturated foot")
   `CHECK_IMPLY(a_inside_equal, clock, reset,
      rsp_tvalid && (status_ff == ST_INSIDE), (kx_ff == fx_ff) && (ky_ff == fy_ff),
      "inside result differs from foot point")
   `CHECK_IMPLY(a_sat_clamped, clock, reset,
      rsp_tvalid && sat_ff, (status_ff == ST_START) || (status_ff == ST_END),
      "foot saturated while u lies inside the segment")
   `CHECK_NEXT(a_stall_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata),
      "stalled result changed")

endmodule

// ===== verif/segment_projection_clamp_test.sv =====
// ----------------------------------------------------------------------------
// segment_projection_clamp_test
// self-checking bench for the clamped point-to-segment projection
// ----------------------------------------------------------------------------
// A queue of queries is filled up front. It starts with hand-picked cases:
// zero-length segments, u exactly 0 and 1, points before and past the
// segment, a saturated quotient, foot overflow and coordinate extremes.
// Random queries follow. A clocked driver feeds the queue into the block
// with random gaps. A clocked monitor takes results with random stalls and
// compares each one against the oldest projection worked out at acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_projection_clamp_test;
   import spc_pkg::*;

   localparam int FRAC      = 24;
   localparam int N_RANDOM  = 1750;
   localparam int DRAIN_CYC = 120;

   typedef struct packed {
      logic [31:0] sx, sy, ex, ey, px, py;
   } query_type;

   typedef struct packed {
      logic [31:0]    kx, ky, fx, fy;
      spc_status_type status;
      logic           sat;
   } proj_type;

   logic          clock;
   logic          reset;
   logic [191:0]  req_tdata;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;

   query_type pending_queries[$];
   proj_type  expected_projs[$];
   int        error_count = 0;
   int        req_gap;
   int        rsp_gap;
   bit        burst_mode;

   segment_projection_clamp DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // s + round(t * d), rounding ties away from zero, saturated to 32 bits
   function automatic logic signed [127:0] move_along(logic signed [127:0] s,
         logic signed [127:0] d, logic signed [127:0] t, output bit sat);
      logic signed [127:0] prod;
      logic [127:0]        mag;
      logic signed [127:0] v;
      prod = t * d;
      mag  = prod < 0 ? -prod : prod;
      mag  = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
      sat  = 1'b0;
      if (mag >= (128'd1 << 62)) begin
         sat = 1'b1;
         return prod < 0 ? -128'sd2147483648 : 128'sd2147483647;
      end
      v = prod < 0 ? s - $signed(mag) : s + $signed(mag);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         v = 128'sd2147483647;
      end else if (v < -128'sd2147483648) begin
         sat = 1'b1;
         v = -128'sd2147483648;
      end
      return v;
   endfunction

   // nearest point on the segment, unclamped foot and clamp status
   function automatic proj_type project_point(query_type q);
      logic signed [127:0] sx, sy, dx, dy, cx, cy, len2, num, u, t, one, lim;
      logic [127:0]        mag, m;
      bit                  s0, s1, dummy;
      proj_type            r;
      sx  = $signed(q.sx);
      sy  = $signed(q.sy);
      dx  = $signed(q.ex) - sx;
      dy  = $signed(q.ey) - sy;
      cx  = $signed(q.px) - sx;
      cy  = $signed(q.py) - sy;
      one = 128'sd1 <<< FRAC;
      lim = 128'sd1 <<< (15 + FRAC);
      len2 = dx * dx + dy * dy;
      if (len2 == 0) begin
         r.kx = q.sx;
         r.ky = q.sy;
         r.fx = q.sx;
         r.fy = q.sy;
         r.status = ST_DEGEN;
         r.sat = 1'b0;
         return r;
      end
      num = cx * dx + cy * dy;
      mag = num < 0 ? -num : num;
      m   = (mag << FRAC) / len2;
      if (m > lim) m = lim;
      u = num < 0 ? -$signed(m) : $signed(m);
      if (u <= 0) begin
         t = 0;
         r.status = ST_START;
      end else if (u >= one) begin
         t = one;
         r.status = ST_END;
      end else begin
         t = u;
         r.status = ST_INSIDE;
      end
      r.fx = 32'(move_along(sx, dx, u, s0));
      r.fy = 32'(move_along(sy, dy, u, s1));
      r.kx = 32'(move_along(sx, dx, t, dummy));
      r.ky = 32'(move_along(sy, dy, t, dummy));
      r.sat = s0 | s1;
      return r;
   endfunction

   // split request data into its fields, first field in the lowest bits
   function automatic query_type unpack_query(logic [191:0] d);
      query_type q;
      q.sx = d[31:0];
      q.sy = d[63:32];
      q.ex = d[95:64];
      q.ey = d[127:96];
      q.px = d[159:128];
      q.py = d[191:160];
      return q;
   endfunction

   function automatic int pick_gap();
      if (burst_mode) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] small_coord();
      return $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 2000)) - 1000);
   endfunction

   // driver: queue to request channel, records expectations on acceptance
   always @(posedge clock) begin
      query_type q;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_projs.push_back(project_point(unpack_query(req_tdata)));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_queries.size() > 0) begin
               q = pending_queries.pop_front();
               req_tdata  <= {q.py, q.px, q.ey, q.ex, q.sy, q.sx};
               req_tvalid <= 1'b1;
               req_gap    <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure and field compare
   always @(posedge clock) begin
      proj_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_projs.size() == 0) begin
               $display("%0t: unexpected result transaction %h %h", $time,
                        rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               e = expected_projs.pop_front();
               if (rsp_tdata[31:0] !== e.kx) begin
                  $display("%0t: clamped_x expected %h actual %h", $time, e.kx,
                           rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[63:32] !== e.ky) begin
                  $display("%0t: clamped_y expected %h actual %h", $time, e.ky,
                           rsp_tdata[63:32]);
                  error_count++;
               end
               if (rsp_tdata[95:64] !== e.fx) begin
                  $display("%0t: foot_x expected %h actual %h", $time, e.fx,
                           rsp_tdata[95:64]);
                  error_count++;
               end
               if (rsp_tdata[127:96] !== e.fy) begin
                  $display("%0t: foot_y expected %h actual %h", $time, e.fy,
                           rsp_tdata[127:96]);
                  error_count++;
               end
               if (rsp_tuser[1:0] !== e.status) begin
                  $display("%0t: clamp_status expected %0d actual %0d", $time,
                           e.status, rsp_tuser[1:0]);
                  error_count++;
               end
               if (rsp_tuser[2] !== e.sat) begin
                  $display("%0t: foot_saturated expected %0d actual %0d", $time,
                           e.sat, rsp_tuser[2]);
                  error_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap    <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap    <= $urandom_range(0, 3) == 0 ? pick_gap() : 0;
         end
      end
   end

   // stimulus and end of run
   initial begin
      query_type q;
      int        k;
      burst_mode  = 1'b0;
      reset       = 1'b1;

      // zero-length segments, at origin and at the extremes
      pending_queries.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 32'h1234, 32'h5678});
      pending_queries.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                  32'h7fffffff, 32'h80000000});
      // point on start (u = 0), on end (u = 1), at midpoint
      pending_queries.push_back('{32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0});
      pending_queries.push_back('{32'h0, 32'h0, 32'h00010000, 32'h0, 32'h00010000, 32'h7});
      pending_queries.push_back('{32'h0, 32'h0, 32'h00020000, 32'h00020000, 32'h00020000,
                                  32'h0});
      // before the start and past the end
      pending_queries.push_back('{32'h00010000, 32'h0, 32'h00030000, 32'h0, 32'hfff00000,
                                  32'h00050000});
      pending_queries.push_back('{32'h00010000, 32'h0, 32'h00030000, 32'h0, 32'h00090000,
                                  32'hfffb0000});
      // tiny segment with far point: quotient saturates both ways, foot overflows
      pending_queries.push_back('{32'h0, 32'h0, 32'h1, 32'h0, 32'h7fffffff, 32'h0});
      pending_queries.push_back('{32'h0, 32'h0, 32'h1, 32'h1, 32'h80000000, 32'h80000000});
      pending_queries.push_back('{32'h10, 32'h10, 32'h11, 32'h10, 32'h7fffffff, 32'h0});
      // foot beyond the coordinate range without quotient saturation
      pending_queries.push_back('{32'h70000000, 32'h0, 32'h7fffffff, 32'h0, 32'h80000000,
                                  32'h80000000});
      pending_queries.push_back('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff});
      pending_queries.push_back('{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h0, 32'h0});
      pending_queries.push_back('{32'h80000000, 32'h0, 32'h7fffffff, 32'h0, 32'hffffffff,
                                  32'h7fffffff});
      pending_queries.push_back('{32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h7fffffff,
                                  32'h80000000});
      pending_queries.push_back('{32'h0, 32'h0, 32'h3, 32'h0, 32'h1, 32'h0});
      pending_queries.push_back('{32'h0, 32'h0, 32'h3, 32'h0, 32'h2, 32'h0});

      for (int i = 0; i < N_RANDOM; i++) begin
         k = $urandom_range(0, 9);
         if (k < 3) begin
            q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end else if (k < 8) begin
            // small coordinates, point near the segment
            q.sx = small_coord();
            q.sy = small_coord();
            q.ex = q.sx + small_coord();
            q.ey = q.sy + small_coord();
            q.px = q.sx + small_coord();
            q.py = q.sy + small_coord();
         end else if (k == 8) begin
            q = '{$urandom, $urandom, 32'h0, 32'h0, $urandom, $urandom};
            q.ex = q.sx;
            q.ey = q.sy;
         end else begin
            // short segment, far point
            q = '{$urandom, $urandom, 32'h0, 32'h0, $urandom, $urandom};
            q.ex = q.sx + $urandom_range(0, 3);
            q.ey = q.sy + $urandom_range(0, 3);
         end
         pending_queries.push_back(q);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // toggle between gapped and back-to-back stretches
      while (pending_queries.size() > 0 || req_tvalid) begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0) burst_mode = !burst_mode;
      end
      burst_mode = 1'b0;
      while (expected_projs.size() > 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/spc_pkg.sv
hw/rtl/spc_divider.sv
hw/rtl/segment_projection_clamp.sv
verif/segment_projection_clamp_test.sv
